>>> rtl/core/md5fb_pkg.sv
// Types, constants and the single-step function of the four-byte MD5 hash pipeline.
package md5fb_pkg;

  localparam int NumSteps = 64;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_st_t;

  localparam md5_st_t MD5_IV = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  // Padding byte lands in word 1 and the bit length of 32 in word 14.
  localparam logic [31:0] PAD_WORD = 32'h0000_0080;
  localparam logic [31:0] LEN_WORD = 32'h0000_0020;

  localparam logic [31:0] K_TABLE [NumSteps] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned ROT_TABLE [16] = '{
    7, 12, 17, 22,
    5, 9, 14, 20,
    4, 11, 16, 23,
    6, 10, 15, 21
  };

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One compression step; the step index is always a constant at each call site.
  function automatic md5_st_t md5_step(input int unsigned i, input md5_st_t s,
                                       input logic [31:0] m);
    md5_st_t     r;
    logic [31:0] f;
    logic [31:0] blk_w;
    logic [31:0] sum;
    int unsigned rnd;
    int unsigned w;
    rnd = i >> 4;
    case (rnd)
      0: begin
        f = (s.b & s.c) | (~s.b & s.d);
        w = i & 15;
      end
      1: begin
        f = (s.d & s.b) | (~s.d & s.c);
        w = (5 * i + 1) & 15;
      end
      2: begin
        f = s.b ^ s.c ^ s.d;
        w = (3 * i + 5) & 15;
      end
      default: begin
        f = s.c ^ (s.b | ~s.d);
        w = (7 * i) & 15;
      end
    endcase
    if (w == 0) begin
      blk_w = m;
    end else if (w == 1) begin
      blk_w = PAD_WORD;
    end else if (w == 14) begin
      blk_w = LEN_WORD;
    end else begin
      blk_w = '0;
    end
    sum = f + s.a + K_TABLE[i[5:0]] + blk_w;
    r.a = s.d;
    r.d = s.c;
    r.c = s.b;
    r.b = s.b + rotl32(sum, ROT_TABLE[{rnd[1:0], i[1:0]}]);
    return r;
  endfunction

endpackage

>>> rtl/core/md5_four_byte_message_hash_core.sv
// Fully unrolled MD5 pipeline for four-byte messages, one compression step per stage.
// A request passes one input register, 64 step stages and one output register holding
// the final addition before m_axis_tvalid_o rises.
// Throughput: one request per cycle; the whole pipeline advances together whenever
// the output register is empty or being taken, so a stall holds every stage.
// Reset clears all valid bits; data registers are not reset.
module md5_four_byte_message_hash_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // [31:0] message_word
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // [31:0] digest_a, [63:32] digest_b,
                                         // [95:64] digest_c, [127:96] digest_d
);
  import md5fb_pkg::*;

  logic                en;
  logic [NumSteps:0]   vld_q;
  logic [31:0]         msg_q [NumSteps];
  md5_st_t             st_q  [1:NumSteps];
  logic                out_vld_q;
  logic [127:0]        out_q;
  md5_st_t             fin;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NumSteps-1:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msg_q[0] <= s_axis_tdata_i;
    end
  end

  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    md5_st_t st_in;
    if (g == 0) begin : g_first
      assign st_in = MD5_IV;
    end else begin : g_rest
      assign st_in = st_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[g+1] <= md5_step(g, st_in, msg_q[g]);
      end
    end

    // The message word is carried as far as the last step; no register is kept beyond it.
    if (g < NumSteps - 1) begin : g_msg
      always_ff @(posedge clk_i) begin
        if (en) begin
          msg_q[g+1] <= msg_q[g];
        end
      end
    end
  end

  always_comb begin
    fin.a = st_q[NumSteps].a + MD5_IV.a;
    fin.b = st_q[NumSteps].b + MD5_IV.b;
    fin.c = st_q[NumSteps].c + MD5_IV.c;
    fin.d = st_q[NumSteps].d + MD5_IV.d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {fin.d, fin.c, fin.b, fin.a};
    end
  end

  // A stalled pipeline keeps every valid bit in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  // An accepted request enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // A request leaving the last step always reaches the output register.
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[NumSteps]) |=> m_axis_tvalid_o)
    else $error("request lost between last step and output");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the four-byte MD5 hash pipeline with stream handshakes.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned RandomRequests = 820;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  localparam logic [31:0] StepConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned StepShift [16] = '{
    7, 12, 17, 22,
    5, 9, 14, 20,
    4, 11, 16, 23,
    6, 10, 15, 21
  };

  typedef enum int unsigned {
    RecvAlways,
    RecvMostly,
    RecvRarely
  } recv_mode_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i;   // [31:0] message_word
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [127:0] m_axis_tdata_o;   // [31:0] digest_a, [63:32] digest_b,
                                  // [95:64] digest_c, [127:96] digest_d

  logic [127:0] digest_queue [$];
  int unsigned  mismatch_count;
  int unsigned  requests_sent;
  int unsigned  digests_checked;
  int unsigned  cycle_count;
  int unsigned  stall_hold;
  recv_mode_e   recv_mode;
  int unsigned  recv_mode_left;

  md5_four_byte_message_hash_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // Digest of a four-byte message: one padded block compressed from the initial values.
  function automatic logic [127:0] md5_digest_of(input logic [31:0] msg);
    logic [31:0] words [16];
    logic [31:0] a, b, c, d, mix, sum;
    int unsigned w, n, rnd;
    for (int k = 0; k < 16; k++) words[k] = '0;
    words[0]  = msg;
    words[1]  = 32'h0000_0080;
    words[14] = 32'd32;
    a = IvA;
    b = IvB;
    c = IvC;
    d = IvD;
    for (int unsigned i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          mix = (b & c) | (~b & d);
          w   = i % 16;
        end
        1: begin
          mix = (d & b) | (~d & c);
          w   = (5 * i + 1) % 16;
        end
        2: begin
          mix = b ^ c ^ d;
          w   = (3 * i + 5) % 16;
        end
        default: begin
          mix = c ^ (b | ~d);
          w   = (7 * i) % 16;
        end
      endcase
      sum = mix + a + StepConst[i] + words[w];
      n   = StepShift[rnd * 4 + i % 4];
      a   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << n) | (sum >> (32 - n)));
    end
    return {d + IvD, c + IvC, b + IvB, a + IvA};
  endfunction

  // Candidate words shaped like a brute-force search, plus plain noise.
  function automatic logic [31:0] random_message();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 1) == 0) word[8*k +: 8] = 8'h00;
        end
      end
      2: begin
        for (int k = 0; k < 4; k++) word[8*k +: 8] = 8'($urandom_range(32, 126));
      end
      default: word = word >> $urandom_range(0, 31);
    endcase
    return word;
  endfunction

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_request(input logic [31:0] word);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    digest_queue.push_back(md5_digest_of(word));
    requests_sent++;
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] words [$];
    words = {32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
             32'h6463_6261, 32'h0000_0061, 32'h6100_0000, 32'h00ff_00ff,
             32'hff00_ff00, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_ff00,
             32'h7fff_ffff, 32'hffff_fffe, 32'h0080_0000, 32'h3030_3030};
    foreach (words[k]) send_request(words[k]);
    // Sender pauses until every digest so far has come back.
    wait_drained();
  endtask

  task automatic test_backpressure();
    // The receiver holds off long enough for the whole pipeline to fill up.
    stall_hold = 300;
    for (int k = 0; k < 160; k++) send_request(random_message());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < RandomRequests) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RandomRequests; k++) begin
        send_request(random_message());
        sent++;
      end
      // Roughly one burst in three runs straight into the next one.
      if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
    end
  endtask

  // Receiver: switches among stall patterns, with an occasional long hold-off.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (recv_mode_left == 0) begin
        recv_mode      <= recv_mode_e'($urandom_range(0, 2));
        recv_mode_left <= $urandom_range(16, 96);
      end else begin
        recv_mode_left <= recv_mode_left - 1;
      end
      case (recv_mode)
        RecvAlways: m_axis_tready_i <= 1'b1;
        RecvMostly: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default:    m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: digest with no request pending, actual %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = digest_queue.pop_front();
        digests_checked++;
        for (int k = 0; k < 4; k++) begin
          if (m_axis_tdata_o[32*k +: 32] !== want[32*k +: 32]) begin
            $display("%0t: digest word %0d expected %h actual %h",
                     $time, k, want[32*k +: 32], m_axis_tdata_o[32*k +: 32]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d digests outstanding", $time, digest_queue.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatch_count  = 0;
    requests_sent   = 0;
    digests_checked = 0;
    cycle_count     = 0;
    stall_hold      = 0;
    recv_mode       = RecvAlways;
    recv_mode_left  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (digest_queue.size() != 0) begin
      $display("%0t: %0d digests never arrived", $time, digest_queue.size());
      mismatch_count++;
    end
    $display("Hashed %0d messages (directed edge words, a pipeline-filling stall, random",
             requests_sent);
    $display("bursts under varied back-pressure); %0d digests compared.", digests_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
